[design/assert_macros.svh]
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("check failed");
`define CHK_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("check failed");
`endif

[design/sia_pkg.sv]
// ----------------------------------------------------------------------------
// sia_pkg
// Opcodes, status codes and shared types of the signed 64-bit ALU.
// ----------------------------------------------------------------------------
package sia_pkg;
   localparam int DataW = 64;
   localparam int QueueDepthDefault = 2;

   typedef enum logic [4:0] {
      OP_SET = 5'd0, OP_ADD = 5'd1, OP_SUB = 5'd2, OP_MUL = 5'd3,
      OP_DIV = 5'd4, OP_MOD = 5'd5, OP_AND = 5'd6, OP_OR = 5'd7,
      OP_XOR = 5'd8, OP_SHR = 5'd9, OP_SHL = 5'd10, OP_EQ = 5'd11,
      OP_NE = 5'd12, OP_GT = 5'd13, OP_LT = 5'd14, OP_GE = 5'd15,
      OP_LE = 5'd16
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_DIVZERO = 2'd1, ST_BADOP = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CLS_SIMPLE = 3'b001, CLS_MUL = 3'b010, CLS_DIV = 3'b100
   } class_type;

   typedef struct packed {
      class_type          cls;
      logic [DataW-1:0]   value;
      logic               became_int;
      status_type         status;
      logic               is_mod;
      logic [DataW-1:0]   lhs;
      logic [DataW-1:0]   rhs;
   } op_type;
endpackage

[design/sia_front.sv]
// ----------------------------------------------------------------------------
// sia_front
// Decodes a beat, finishes the simple operations and registers it.
// ----------------------------------------------------------------------------
module sia_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [4:0]           req_mode,
   input  logic [63:0]          req_lhs,
   input  logic [63:0]          req_rhs,
   output logic                 op_valid,
   input  logic                 op_ready,
   output sia_pkg::op_type      op_data
);
   import sia_pkg::*;

   logic   valid_ff, valid_in;
   op_type data_ff, data_in;
   logic   lt_ab, lt_ba;
   logic [5:0] sh;

   assign req_ready = !valid_ff || op_ready;
   assign op_valid  = valid_ff;
   assign op_data   = data_ff;
   assign lt_ab = $signed(req_lhs) < $signed(req_rhs);
   assign lt_ba = $signed(req_rhs) < $signed(req_lhs);
   assign sh = req_rhs[5:0];

   always_comb begin
      data_in = '0;
      data_in.cls = CLS_SIMPLE;
      data_in.value = req_lhs;
      data_in.status = ST_OK;
      data_in.lhs = req_lhs;
      data_in.rhs = req_rhs;
      case (req_mode)
         OP_SET: data_in.value = req_rhs;
         OP_ADD: data_in.value = req_lhs + req_rhs;
         OP_SUB: data_in.value = req_lhs - req_rhs;
         OP_MUL: data_in.cls = CLS_MUL;
         OP_DIV, OP_MOD: begin
            data_in.is_mod = (req_mode == OP_MOD);
            if (req_rhs == '0) data_in.status = ST_DIVZERO;
            else data_in.cls = CLS_DIV;
         end
         OP_AND: data_in.value = req_lhs & req_rhs;
         OP_OR:  data_in.value = req_lhs | req_rhs;
         OP_XOR: data_in.value = req_lhs ^ req_rhs;
         OP_SHR: data_in.value = $unsigned($signed(req_lhs) >>> sh);
         OP_SHL: data_in.value = req_lhs << sh;
         OP_EQ: begin data_in.value = {63'd0, req_lhs == req_rhs}; data_in.became_int = 1'b1; end
         OP_NE: begin data_in.value = {63'd0, req_lhs != req_rhs}; data_in.became_int = 1'b1; end
         OP_GT: begin data_in.value = {63'd0, lt_ba}; data_in.became_int = 1'b1; end
         OP_LT: begin data_in.value = {63'd0, lt_ab}; data_in.became_int = 1'b1; end
         OP_GE: begin data_in.value = {63'd0, !lt_ab}; data_in.became_int = 1'b1; end
         OP_LE: begin data_in.value = {63'd0, !lt_ba}; data_in.became_int = 1'b1; end
         default: data_in.status = ST_BADOP;
      endcase
   end

   assign valid_in = req_valid ? 1'b1 : (op_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (req_ready) valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) data_ff <= data_in;
   end
endmodule

[design/sia_queue.sv]
// ----------------------------------------------------------------------------
// sia_queue
// Small FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module sia_queue #(
   parameter int Depth = sia_pkg::QueueDepthDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  sia_pkg::op_type      in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output sia_pkg::op_type      out_data
);
   import sia_pkg::*;
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   op_type        mem [Depth];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;
   logic          push, pop;

   assign in_ready  = cnt_ff != (AW+1)'(Depth);
   assign out_valid = cnt_ff != '0;
   assign out_data  = mem[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == AW'(Depth-1)) ? '0 : wp_ff + 1'b1;
         if (pop)  rp_ff <= (rp_ff == AW'(Depth-1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem[wp_ff] <= in_data;
   end
endmodule

[design/sia_back.sv]
// ----------------------------------------------------------------------------
// sia_back
// Executes multiply (three partial products, then their sum) and divide (radix-2,
// 64 steps) and drives the registered result channel.
// ----------------------------------------------------------------------------
module sia_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 op_valid,
   output logic                 op_ready,
   input  sia_pkg::op_type      op_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [63:0]          rsp_value,
   output logic                 rsp_became_int,
   output logic [1:0]           rsp_status
);
   import sia_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001, S_MUL = 4'b0010, S_DIV = 4'b0100, S_FIX = 4'b1000
   } state_type;

   state_type   st_ff;
   logic        ov_ff, ov_in;
   logic [63:0] val_ff, res_in;
   logic        bi_ff;
   logic [1:0]  stat_ff;
   logic [63:0] p0_ff;
   logic [31:0] p1_ff, p2_ff;
   logic [63:0] q_ff, r_ff, d_ff;
   logic [6:0]  n_ff;
   logic        mod_ff, nq_ff, nr_ff;
   logic        out_free, take, done, load;
   logic [64:0] rsh;
   logic [64:0] rdiff;
   logic [63:0] ma, mb;

   assign out_free = !ov_ff || rsp_ready;
   assign op_ready = (st_ff == S_IDLE) && out_free;
   assign take = op_valid && op_ready;
   assign rsp_valid = ov_ff;
   assign rsp_value = val_ff;
   assign rsp_became_int = bi_ff;
   assign rsp_status = stat_ff;

   assign load  = (take && op_data.cls == CLS_SIMPLE) || done;
   assign ov_in = (ov_ff && !rsp_ready) || load;

   assign ma = op_data.lhs[63] ? 64'(0 - op_data.lhs) : op_data.lhs;
   assign mb = op_data.rhs[63] ? 64'(0 - op_data.rhs) : op_data.rhs;
   assign rsh = {r_ff, q_ff[63]};
   assign rdiff = rsh - {1'b0, d_ff};

   always_comb begin
      done = 1'b0;
      res_in = '0;
      case (st_ff)
         S_MUL: begin
            done = out_free;
            res_in = p0_ff + {p1_ff, 32'd0} + {p2_ff, 32'd0};
         end
         S_FIX: begin
            done = out_free;
            if (mod_ff) res_in = nr_ff ? 64'(0 - r_ff) : r_ff;
            else res_in = nq_ff ? 64'(0 - q_ff) : q_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= ov_in;
         case (st_ff)
            S_IDLE: if (take) begin
               if (op_data.cls == CLS_MUL) st_ff <= S_MUL;
               else if (op_data.cls == CLS_DIV) st_ff <= S_DIV;
            end
            S_MUL: if (done) st_ff <= S_IDLE;
            S_DIV: if (n_ff == 7'd63) st_ff <= S_FIX;
            S_FIX: if (done) st_ff <= S_IDLE;
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         val_ff  <= op_data.value;
         bi_ff   <= op_data.became_int;
         stat_ff <= op_data.status;
         q_ff <= ma;
         d_ff <= mb;
         r_ff <= '0;
         n_ff <= '0;
         mod_ff <= op_data.is_mod;
         nq_ff <= op_data.lhs[63] ^ op_data.rhs[63];
         nr_ff <= op_data.lhs[63];
         p0_ff <= op_data.lhs[31:0] * op_data.rhs[31:0];
         p1_ff <= 32'(op_data.lhs[63:32] * op_data.rhs[31:0]);
         p2_ff <= 32'(op_data.lhs[31:0] * op_data.rhs[63:32]);
      end else if (st_ff == S_DIV) begin
         n_ff <= n_ff + 1'b1;
         if (!rdiff[64]) begin
            r_ff <= rdiff[63:0];
            q_ff <= {q_ff[62:0], 1'b1};
         end else begin
            r_ff <= rsh[63:0];
            q_ff <= {q_ff[62:0], 1'b0};
         end
      end
      if (done) val_ff <= res_in;
   end
endmodule

[design/signed_int64_alu.sv]
// ----------------------------------------------------------------------------
// signed_int64_alu
// Signed 64-bit ALU: front decode, queue, back execution units.
// ----------------------------------------------------------------------------
// channel  | ports                                 | dir
// req      | valid ready mode lhs rhs              | in
// rsp      | valid ready value became_int status   | out
// Simple ops: one beat per cycle while nothing stalls; rsp_valid is registered
//   through the front reg, the queue and the result reg after the req accept.
// Multiply: holds the back while three 32x32 partial products are formed, then summed.
// Divide/modulo by a nonzero divisor: holds the back through the 64-step radix-2 loop and a sign fix.
// Reset clears only control state, not data registers; stalls on rsp back up through the queue.
module signed_int64_alu #(
   parameter int QueueDepth = sia_pkg::QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [4:0]  req_mode,
   input  logic [63:0] req_lhs,
   input  logic [63:0] req_rhs,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_value,
   output logic        rsp_became_int,
   output logic [1:0]  rsp_status
);
   import sia_pkg::*;

   logic   f_valid, f_ready, b_valid, b_ready;
   op_type f_data, b_data;

   sia_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_mode, .req_lhs, .req_rhs,
      .op_valid(f_valid), .op_ready(f_ready), .op_data(f_data)
   );

   sia_queue #(.Depth(QueueDepth)) u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
   );

   sia_back u_back (
      .clock, .reset,
      .op_valid(b_valid), .op_ready(b_ready), .op_data(b_data),
      .rsp_valid, .rsp_ready, .rsp_value, .rsp_became_int, .rsp_status
   );
endmodule

[design/sia_checker.sv]
// ----------------------------------------------------------------------------
// sia_checker
// Port-level checks of the signed 64-bit ALU.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sia_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_value,
   input logic        rsp_became_int,
   input logic [1:0]  rsp_status
);
   import sia_pkg::*;

   logic status_known, cmp_clean;

   assign status_known = rsp_status == ST_OK || rsp_status == ST_DIVZERO ||
                         rsp_status == ST_BADOP;
   assign cmp_clean = rsp_value[63:1] == '0 && rsp_status == ST_OK;

   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value))
   `CHK_IMPL(a_status, clock, reset, rsp_valid, status_known)
   `CHK_IMPL(a_cmp_bool, clock, reset, rsp_valid && rsp_became_int, cmp_clean)
   `CHK_NEXT(a_rst_idle, clock, 1'b0, reset, !rsp_valid)
endmodule

bind signed_int64_alu sia_checker u_sia_checker (.*);
